// ----- rtl/hrmd_pkg.sv -----
package hrmd_pkg;

  localparam int REPORT_BYTES_DEFAULT = 64;
  localparam int POS_W = 6;
  localparam int LEN_W = 10;
  localparam logic [LEN_W-1:0] MAX_MESSAGE_BYTES_RESET = 10'd260;

  localparam logic [1:0] FLAG_CMD_BODY   = 2'd0;
  localparam logic [1:0] FLAG_CMD_LAST   = 2'd1;
  localparam logic [1:0] FLAG_SERIAL_OUT = 2'd2;
  localparam logic [1:0] FLAG_SERIAL_ERR = 2'd3;

  typedef enum logic [1:0] {
    KIND_COMMAND    = 2'd0,
    KIND_SERIAL_OUT = 2'd1,
    KIND_SERIAL_ERR = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE              = 2'd0,
    ERR_SERIAL_IN_COMMAND = 2'd1,
    ERR_TOO_LARGE         = 2'd2
  } err_t;

  typedef struct packed {
    logic [7:0] report_byte;
    logic       first_of_report;
  } item_t;

  typedef struct packed {
    logic             has_data;
    logic [7:0]       payload_byte;
    kind_t            message_kind;
    logic             end_of_message;
    logic [LEN_W-1:0] message_length;
    err_t             error_code;
  } result_t;

endpackage

// ----- rtl/hid_report_message_deframer.sv -----
// Reassembles HF2-style messages from the bytes of HID reports, one byte per request on the
// slave side. A request with tuser set carries the report header; payload bytes come out
// tagged with the message kind, the last one with tlast and the total message length, and a
// dropped report yields one error request. A byte is taken every cycle while the output buffer
// has room, and passes an input register and the header/payload logic into a two-entry output
// buffer that offers its result on the master side. The user must write the maximum message
// length through cfg_wr_en and cfg_wr_data while the block is idle; it does not enforce this.
module hid_report_message_deframer
  import hrmd_pkg::*;
#(
  parameter int REPORT_BYTES = REPORT_BYTES_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [7:0]       s_axis_tdata,   // report_byte
  input  logic             s_axis_tuser,   // first_of_report
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // payload_byte, message_length, zero fill
  output logic [4:0]       m_axis_tuser,   // has_data, message_kind, error_code
  output logic             m_axis_tlast,   // end_of_message
  input  logic             cfg_wr_en,
  input  logic [LEN_W-1:0] cfg_wr_data
);

  logic [LEN_W-1:0] max_message_bytes;
  logic             in_valid;
  item_t            in_item;
  logic             room;
  logic             advance;
  logic             accept;
  logic             res_valid;
  result_t          res;
  result_t          out_res;

  assign advance       = in_valid && room;
  assign s_axis_tready = !in_valid || room;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_message_bytes <= MAX_MESSAGE_BYTES_RESET;
      in_valid          <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        max_message_bytes <= cfg_wr_data;
      end
      in_valid <= accept || (in_valid && !advance);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_item.report_byte     <= s_axis_tdata;
      in_item.first_of_report <= s_axis_tuser;
    end
  end

  hrmd_core #(
    .REPORT_BYTES(REPORT_BYTES)
  ) u_core (
    .clk              (clk),
    .rst              (rst),
    .en               (advance),
    .item             (in_item),
    .max_message_bytes(max_message_bytes),
    .res_valid        (res_valid),
    .res              (res)
  );

  hrmd_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .push     (res_valid),
    .push_data(res),
    .room     (room),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_data (out_res)
  );

  assign m_axis_tdata = {6'd0, out_res.message_length, out_res.payload_byte};
  assign m_axis_tuser = {out_res.error_code, out_res.message_kind, out_res.has_data};
  assign m_axis_tlast = out_res.end_of_message;

endmodule

// ----- rtl/hrmd_core.sv -----
module hrmd_core
  import hrmd_pkg::*;
#(
  parameter int REPORT_BYTES = REPORT_BYTES_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  item_t            item,
  input  logic [LEN_W-1:0] max_message_bytes,
  output logic             res_valid,
  output result_t          res
);

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(REPORT_BYTES - 1);

  logic [POS_W-1:0] position, position_next;
  logic [POS_W-1:0] payload_size, payload_size_next;
  kind_t            report_kind, report_kind_next;
  logic             dropped, dropped_next;
  logic             ends_message, ends_message_next;
  logic [LEN_W-1:0] acc_length, acc_length_next;

  logic [1:0]       flag;
  logic [POS_W-1:0] size_raw;
  logic [POS_W-1:0] size;
  kind_t            hdr_kind;
  logic [LEN_W-1:0] acc_base;
  logic [LEN_W:0]   sum;
  logic [POS_W-1:0] pos_inc;

  always_comb begin
    flag     = item.report_byte[7:6];
    size_raw = item.report_byte[POS_W-1:0];
    size     = (size_raw > LAST_POS) ? LAST_POS : size_raw;
    case (flag)
      FLAG_SERIAL_OUT: hdr_kind = KIND_SERIAL_OUT;
      FLAG_SERIAL_ERR: hdr_kind = KIND_SERIAL_ERR;
      default:         hdr_kind = KIND_COMMAND;
    endcase
    acc_base = ends_message ? '0 : acc_length;
    sum      = {1'b0, acc_base} + (LEN_W+1)'(size);
    pos_inc  = position + POS_W'(1);
  end

  always_comb begin
    position_next     = position;
    payload_size_next = payload_size;
    report_kind_next  = report_kind;
    dropped_next      = dropped;
    ends_message_next = ends_message;
    acc_length_next   = acc_length;
    res_valid         = 1'b0;
    res               = '0;
    if (en) begin
      if (item.first_of_report) begin
        position_next     = '0;
        report_kind_next  = hdr_kind;
        ends_message_next = 1'b0;
        acc_length_next   = acc_base;
        res.message_kind  = hdr_kind;
        if (acc_base != '0 && (flag inside {FLAG_SERIAL_OUT, FLAG_SERIAL_ERR})) begin
          dropped_next      = 1'b1;
          payload_size_next = '0;
          res_valid         = 1'b1;
          res.error_code    = ERR_SERIAL_IN_COMMAND;
        end else if (sum > {1'b0, max_message_bytes}) begin
          dropped_next      = 1'b1;
          payload_size_next = '0;
          res_valid         = 1'b1;
          res.error_code    = ERR_TOO_LARGE;
        end else begin
          dropped_next      = 1'b0;
          payload_size_next = size;
          acc_length_next   = sum[LEN_W-1:0];
          if (flag != FLAG_CMD_BODY) begin
            if (size == '0) begin
              res_valid          = 1'b1;
              res.end_of_message = 1'b1;
              res.message_length = sum[LEN_W-1:0];
              acc_length_next    = '0;
            end else begin
              ends_message_next = 1'b1;
            end
          end
        end
      end else if (position < LAST_POS) begin
        position_next = pos_inc;
        if (!dropped && pos_inc <= payload_size) begin
          res_valid        = 1'b1;
          res.has_data     = 1'b1;
          res.payload_byte = item.report_byte;
          res.message_kind = report_kind;
          if (pos_inc == payload_size && ends_message) begin
            res.end_of_message = 1'b1;
            res.message_length = acc_length;
            acc_length_next    = '0;
            ends_message_next  = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position     <= '0;
      payload_size <= '0;
      report_kind  <= KIND_COMMAND;
      dropped      <= 1'b0;
      ends_message <= 1'b0;
      acc_length   <= '0;
    end else begin
      position     <= position_next;
      payload_size <= payload_size_next;
      report_kind  <= report_kind_next;
      dropped      <= dropped_next;
      ends_message <= ends_message_next;
      acc_length   <= acc_length_next;
    end
  end

  a_err_no_data: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.error_code != ERR_NONE |-> !res.has_data && !res.end_of_message)
    else $error("error request carries data or an end mark");

  a_end_clears_length: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.end_of_message |=> acc_length == '0)
    else $error("message length not cleared after end of message");

  a_dropped_no_payload: assert property (@(posedge clk) disable iff (rst)
    dropped |-> payload_size == '0 && !ends_message)
    else $error("dropped report still expects payload");

endmodule

// ----- rtl/hrmd_out_buf.sv -----
module hrmd_out_buf
  import hrmd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    room,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  result_t    entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = count != 2'd0;
  assign room      = count != 2'd2;
  assign out_data  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> room)
    else $error("request written into a full output buffer");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3 && ((count == 2'd0) == (wr_ptr == rd_ptr) || count == 2'd2))
    else $error("output buffer count and pointers disagree");

endmodule

// ----- sim/hid_report_message_deframer_tb.sv -----
module hid_report_message_deframer_tb;
  import hrmd_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_REPORTED = 10;

  logic             clk;
  logic             rst;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [7:0]       s_axis_tdata;
  logic             s_axis_tuser;
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [23:0]      m_axis_tdata;
  logic [4:0]       m_axis_tuser;
  logic             m_axis_tlast;
  logic             cfg_wr_en;
  logic [LEN_W-1:0] cfg_wr_data;

  hid_report_message_deframer dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  // Predictor state of the deframer.
  logic [POS_W-1:0] rep_pos = '0;
  logic [POS_W-1:0] rep_size = '0;
  kind_t            rep_kind = KIND_COMMAND;
  logic             rep_dropped = 1'b0;
  logic             rep_final = 1'b0;
  logic [LEN_W-1:0] msg_len = '0;
  logic [LEN_W-1:0] max_len = MAX_MESSAGE_BYTES_RESET;

  result_t deframed_out[$];
  int      mismatches = 0;
  int      cycles = 0;
  int      accepted_bytes = 0;
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic result_t make_result(logic has, logic [7:0] b, kind_t k, logic last,
                                          logic [LEN_W-1:0] len, err_t e);
    result_t r;
    r.has_data = has;
    r.payload_byte = b;
    r.message_kind = k;
    r.end_of_message = last;
    r.message_length = len;
    r.error_code = e;
    return r;
  endfunction

  function automatic void deframe_byte(logic [7:0] b, logic first);
    logic [1:0]       flag;
    logic [POS_W-1:0] size;
    kind_t            k;
    if (first) begin
      flag = b[7:6];
      size = b[5:0];
      k = (flag <= FLAG_CMD_LAST) ? KIND_COMMAND : kind_t'(flag - 2'd1);
      if (int'(size) > REPORT_BYTES_DEFAULT - 1) size = POS_W'(REPORT_BYTES_DEFAULT - 1);
      if (rep_final) begin
        msg_len = '0;
        rep_final = 1'b0;
      end
      rep_pos = '0;
      rep_kind = k;
      if (msg_len != 0 && flag[1]) begin
        rep_dropped = 1'b1;
        rep_size = '0;
        deframed_out.push_back(make_result(1'b0, 8'h00, k, 1'b0, '0, ERR_SERIAL_IN_COMMAND));
      end else if (int'(msg_len) + int'(size) > int'(max_len)) begin
        rep_dropped = 1'b1;
        rep_size = '0;
        deframed_out.push_back(make_result(1'b0, 8'h00, k, 1'b0, '0, ERR_TOO_LARGE));
      end else begin
        rep_dropped = 1'b0;
        rep_size = size;
        msg_len = msg_len + LEN_W'(size);
        if (flag != FLAG_CMD_BODY) begin
          if (size == 0) begin
            deframed_out.push_back(make_result(1'b0, 8'h00, k, 1'b1, msg_len, ERR_NONE));
            msg_len = '0;
          end else begin
            rep_final = 1'b1;
          end
        end
      end
    end else if (int'(rep_pos) < REPORT_BYTES_DEFAULT - 1) begin
      rep_pos = rep_pos + 1'b1;
      if (!rep_dropped && rep_pos <= rep_size) begin
        if (rep_pos == rep_size && rep_final) begin
          deframed_out.push_back(make_result(1'b1, b, rep_kind, 1'b1, msg_len, ERR_NONE));
          msg_len = '0;
          rep_final = 1'b0;
        end else begin
          deframed_out.push_back(make_result(1'b1, b, rep_kind, 1'b0, '0, ERR_NONE));
        end
      end
    end
  endfunction

  function automatic void note_failure(string what, result_t want, result_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTED) begin
      $display("%s: expected has=%0d byte=%02h kind=%0d last=%0d len=%0d err=%0d",
               what, want.has_data, want.payload_byte, want.message_kind,
               want.end_of_message, want.message_length, want.error_code);
      $display("  got has=%0d byte=%02h kind=%0d last=%0d len=%0d err=%0d",
               got.has_data, got.payload_byte, got.message_kind, got.end_of_message,
               got.message_length, got.error_code);
    end
  endfunction

  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.has_data = m_axis_tuser[0];
      got.message_kind = kind_t'(m_axis_tuser[2:1]);
      got.error_code = err_t'(m_axis_tuser[4:3]);
      got.payload_byte = m_axis_tdata[7:0];
      got.message_length = m_axis_tdata[17:8];
      got.end_of_message = m_axis_tlast;
      if (deframed_out.size() == 0) begin
        note_failure("unexpected request", '0, got);
      end else begin
        want = deframed_out.pop_front();
        if (got.has_data !== want.has_data || got.payload_byte !== want.payload_byte ||
            got.message_kind !== want.message_kind ||
            got.end_of_message !== want.end_of_message ||
            got.message_length !== want.message_length ||
            got.error_code !== want.error_code)
          note_failure("mismatch", want, got);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic first);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tuser <= first;
    do @(posedge clk); while (!s_axis_tready);
    deframe_byte(b, first);
    accepted_bytes++;
    @(negedge clk);
  endtask

  task automatic send_report(input logic [1:0] flag, input int size, input int pad);
    push_byte({flag, size[5:0]}, 1'b1);
    repeat (size + pad) push_byte(8'($urandom_range(255)), 1'b0);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (deframed_out.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_max_length(input logic [LEN_W-1:0] value);
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    max_len = value;
  endtask

  task automatic test_directed();
    push_byte(8'hA5, 1'b0);
    push_byte(8'h5A, 1'b0);
    push_byte({FLAG_CMD_BODY, 6'd3}, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h3C, 1'b0);
    push_byte({FLAG_CMD_LAST, 6'd2}, 1'b1);
    push_byte(8'h81, 1'b0);
    push_byte(8'h7E, 1'b0);
    push_byte(8'h11, 1'b0);
    send_report(FLAG_CMD_BODY, 1, 0);
    send_report(FLAG_CMD_LAST, 0, 0);
    send_report(FLAG_SERIAL_OUT, 0, 0);
    send_report(FLAG_SERIAL_ERR, 1, 0);
    send_report(FLAG_CMD_BODY, 1, 0);
    send_report(FLAG_SERIAL_OUT, 1, 0);
    send_report(FLAG_SERIAL_ERR, 0, 0);
    send_report(FLAG_CMD_LAST, 3, 0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b1);
  endtask

  task automatic test_length_limits();
    wait_drained();
    push_byte({FLAG_CMD_LAST, 6'd1}, 1'b1);
    wait_drained();
    write_max_length(10'd1);
    send_report(FLAG_CMD_LAST, 1, 1);
    send_report(FLAG_SERIAL_OUT, 2, 0);
    send_report(FLAG_CMD_BODY, 1, 0);
    send_report(FLAG_CMD_LAST, 1, 0);
    send_report(FLAG_CMD_LAST, 1, 0);
    write_max_length(10'd0);
    send_report(FLAG_SERIAL_ERR, 1, 0);
    send_report(FLAG_CMD_LAST, 0, 0);
    send_report(FLAG_SERIAL_OUT, 0, 0);
  endtask

  task automatic test_long_message();
    write_max_length(10'd300);
    repeat (4) send_report(FLAG_CMD_BODY, 63, 0);
    send_report(FLAG_CMD_LAST, 49, 0);
    send_report(FLAG_CMD_LAST, 48, 0);
    send_report(FLAG_SERIAL_ERR, 63, 3);
  endtask

  task automatic test_random_reports(input int n, input int idle, input int stall);
    int          start;
    int          pick;
    int          size;
    int          pad;
    logic [1:0]  flag;
    logic        paused;
    paused = 1'b0;
    if ($urandom_range(1)) write_max_length(LEN_W'($urandom_range(1, 80)));
    else write_max_length(LEN_W'($urandom_range(1, 1023)));
    send_idle_pct = idle;
    recv_stall_pct = stall;
    start = accepted_bytes;
    while (accepted_bytes - start < n) begin
      if (!paused && accepted_bytes - start >= n / 2) begin
        wait_drained();
        paused = 1'b1;
      end
      pick = $urandom_range(99);
      flag = 2'($urandom_range(3));
      if ($urandom_range(2) == 0) flag = FLAG_CMD_BODY;
      size = ($urandom_range(4) == 0) ? $urandom_range(63) : $urandom_range(12);
      if (pick < 70) begin
        pad = $urandom_range(9);
        if (pad < 7) pad = 0;
        else if (pad < 9) pad = $urandom_range(1, 3);
        else pad = 63 - size + $urandom_range(3);
        send_report(flag, size, pad);
      end else if (pick < 85) begin
        if (size < 2) size = 2;
        push_byte({flag, 6'(size)}, 1'b1);
        repeat ($urandom_range(size - 1)) push_byte(8'($urandom_range(255)), 1'b0);
      end else begin
        repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(255)), 1'b0);
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    m_axis_tready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_length_limits();
    test_long_message();
    test_random_reports(150, 0, 0);
    test_random_reports(140, 82, 0);
    test_random_reports(140, 0, 82);
    test_random_reports(140, 24, 24);
    write_max_length(MAX_MESSAGE_BYTES_RESET);
    test_random_reports(90, 0, 0);
    wait_drained();
    repeat (10) @(negedge clk);
    if (mismatches == 0 && deframed_out.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
